[hdl/odl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered deque list package
// Shared sizes, operation and status codes, and the cell control types.
// ----------------------------------------------------------------------------
package odl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT    = 3'd0,
    OP_PUSH_BACK     = 3'd1,
    OP_INSERT_SORTED = 3'd2,
    OP_POP_FRONT     = 3'd3,
    OP_POP_BACK      = 3'd4,
    OP_REMOVE_VALUE  = 3'd5,
    OP_CLEAR         = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // What a cell loads at the next clock edge.
  typedef enum logic [1:0] {
    CMD_HOLD      = 2'd0,
    CMD_LOAD      = 2'd1,
    CMD_FROM_PREV = 2'd2,
    CMD_FROM_NEXT = 2'd3
  } cell_cmd_e;

  // Compare flags that a cell reports against the operand.
  typedef struct packed {
    logic lt;  // stored entry is below the operand
    logic eq;  // stored entry equals the operand
  } cell_flags_t;

endpackage

[hdl/odl_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered deque list cell
// Holds one list entry, compares it with the operand and shifts to a neighbor.
// ----------------------------------------------------------------------------
module odl_cell
  import odl_pkg::*;
(
  input  logic                     clk_i,
  input  cell_cmd_e                cmd_i,
  input  logic signed [DATA_W-1:0] operand_i,
  input  logic signed [DATA_W-1:0] prev_i,
  input  logic signed [DATA_W-1:0] next_i,
  output logic signed [DATA_W-1:0] entry_o,
  output cell_flags_t              flags_o
);

  logic signed [DATA_W-1:0] entry_q, entry_d;

  always_comb begin
    case (cmd_i)
      CMD_LOAD:      entry_d = operand_i;
      CMD_FROM_PREV: entry_d = prev_i;
      CMD_FROM_NEXT: entry_d = next_i;
      default:       entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o    = entry_q;
  assign flags_o.lt = (entry_q < operand_i);
  assign flags_o.eq = (entry_q == operand_i);

endmodule

[hdl/odl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered deque list controller
// Picks the insert or remove position from the cell flags and steers the row.
// ----------------------------------------------------------------------------
module odl_ctrl
  import odl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [2:0]               operation_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [CNT_W-1:0]         count_o,
  output logic signed [DATA_W-1:0] front_value_o,
  output logic signed [DATA_W-1:0] back_value_o,
  output logic signed [DATA_W-1:0] removed_value_o,
  output logic signed [DATA_W-1:0] operand_o,
  output cell_cmd_e                cmd_o     [CAPACITY],
  input  logic signed [DATA_W-1:0] entries_i [CAPACITY],
  input  cell_flags_t              flags_i   [CAPACITY]
);

  logic                     busy_q, done_q;
  logic [2:0]               op_q;
  logic signed [DATA_W-1:0] operand_q;
  logic [CNT_W-1:0]         count_q, count_d;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] removed_q, removed_d;

  logic [IDX_W-1:0] tail_idx, pos_idx;
  logic [CNT_W-1:0] ins_scan, rem_scan, pos;
  logic             do_insert, do_remove;
  logic             full, empty;

  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign tail_idx = IDX_W'(count_q - 1'b1);
  assign pos_idx  = IDX_W'(pos);

  // First inner entry that is not below the operand, one scan per operation.
  always_comb begin
    ins_scan = count_q;
    rem_scan = count_q - 1'b1;
    for (int i = CAPACITY - 1; i >= 1; i--) begin
      if ((CNT_W'(i) < count_q) && !flags_i[i].lt) begin
        ins_scan = CNT_W'(i);
      end
      if ((CNT_W'(i) < count_q - 1'b1) && !flags_i[i].lt) begin
        rem_scan = CNT_W'(i);
      end
    end
  end

  always_comb begin
    status_d  = ST_OK;
    removed_d = '0;
    count_d   = count_q;
    do_insert = 1'b0;
    do_remove = 1'b0;
    pos       = '0;
    case (op_q)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_SORTED: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_insert = 1'b1;
          if (op_q == OP_PUSH_FRONT) begin
            pos = '0;
          end else if (op_q == OP_PUSH_BACK || empty) begin
            pos = count_q;
          end else if (!flags_i[0].lt && !flags_i[0].eq) begin
            pos = '0;
          end else if (flags_i[tail_idx].lt) begin
            pos = count_q;
          end else begin
            pos = ins_scan;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_VALUE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (op_q == OP_POP_FRONT) begin
          do_remove = 1'b1;
          pos       = '0;
        end else if (op_q == OP_POP_BACK) begin
          do_remove = 1'b1;
          pos       = count_q - 1'b1;
        end else if (flags_i[0].eq) begin
          do_remove = 1'b1;
          pos       = '0;
        end else if (count_q == CNT_W'(1)) begin
          status_d = ST_NOTFOUND;
        end else if (flags_i[tail_idx].eq) begin
          do_remove = 1'b1;
          pos       = count_q - 1'b1;
        end else begin
          pos = rem_scan;
          if (flags_i[IDX_W'(rem_scan)].eq) begin
            do_remove = 1'b1;
          end else begin
            status_d = ST_NOTFOUND;
          end
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    if (do_insert) begin
      count_d = count_q + 1'b1;
    end
    if (do_remove) begin
      count_d   = count_q - 1'b1;
      removed_d = entries_i[pos_idx];
    end
  end

  // Steer each cell: open a gap for an insert, close one for a removal.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmd_o[i] = CMD_HOLD;
      if (busy_q && do_insert) begin
        if (CNT_W'(i) > pos) begin
          cmd_o[i] = CMD_FROM_PREV;
        end else if (CNT_W'(i) == pos) begin
          cmd_o[i] = CMD_LOAD;
        end
      end else if (busy_q && do_remove && (CNT_W'(i) >= pos)) begin
        cmd_o[i] = CMD_FROM_NEXT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      count_q  <= '0;
      status_q <= ST_OK;
    end else begin
      done_q <= busy_q;
      if (busy_q) begin
        busy_q   <= 1'b0;
        count_q  <= count_d;
        status_q <= status_d;
      end else if (start_i) begin
        busy_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      op_q      <= operation_i;
      operand_q <= value_i;
    end
    if (busy_q) begin
      removed_q <= removed_d;
    end
  end

  assign busy_o          = busy_q;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign count_o         = count_q;
  assign removed_value_o = removed_q;
  assign operand_o       = operand_q;
  assign front_value_o   = empty ? '0 : entries_i[0];
  assign back_value_o    = empty ? '0 : entries_i[tail_idx];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("list count above capacity");
  a_done_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("result strobe without an executed transaction");
  a_single_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q)
    else $error("execute cycle lasted more than one cycle");
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_FULL) |-> (count_q == CNT_W'(CAPACITY)))
    else $error("full status with room left");
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_EMPTY) |-> (count_q == '0))
    else $error("empty status on a non-empty list");
`endif

endmodule

[hdl/ordered_deque_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered deque list engine
// Bounded list of signed 32-bit values with deque and sorted operations.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a rising edge with start_i high and
//   busy_o low; operation_i and value_i are sampled then. The next cycle is
//   the execute cycle (busy_o high): every cell compares its entry with the
//   operand in parallel, the controller picks the position, and the row of
//   cells shifts left or right around it at the end of that cycle.
//   In the cycle after that, done_o is high for exactly one cycle with the
//   status, count, front, back and removed values. The receiver cannot stall
//   the result; a new command may be given in that same cycle.
//   No new command is taken while busy_o is high, that is, during the
//   compare-and-shift pass over the cell row.
//   Reset empties the list at once (count zero); entry contents are left
//   unchanged and are never shown while the count excludes them.
// ----------------------------------------------------------------------------
module ordered_deque_list_engine
  import odl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [2:0]               operation_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [CNT_W-1:0]         count_o,
  output logic signed [DATA_W-1:0] front_value_o,
  output logic signed [DATA_W-1:0] back_value_o,
  output logic signed [DATA_W-1:0] removed_value_o
);

  logic signed [DATA_W-1:0] operand;
  cell_cmd_e                cmd     [CAPACITY];
  logic signed [DATA_W-1:0] entries [CAPACITY];
  cell_flags_t              flags   [CAPACITY];

  odl_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .status_o        (status_o),
    .count_o         (count_o),
    .front_value_o   (front_value_o),
    .back_value_o    (back_value_o),
    .removed_value_o (removed_value_o),
    .operand_o       (operand),
    .cmd_o           (cmd),
    .entries_i       (entries),
    .flags_i         (flags)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] prev_entry, next_entry;

    if (g == 0) begin : g_first
      assign prev_entry = '0;
    end else begin : g_inner_prev
      assign prev_entry = entries[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner_next
      assign next_entry = entries[g+1];
    end

    odl_cell u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd[g]),
      .operand_i (operand),
      .prev_i    (prev_entry),
      .next_i    (next_entry),
      .entry_o   (entries[g]),
      .flags_o   (flags[g])
    );
  end

endmodule
